// File: rtl/line_follower_pd_drive_core_macros.svh
// Assertion macros shared by the line follower drive RTL.
// Users must have clk and arst_n in scope; no other dependencies.
`ifndef LINE_FOLLOWER_PD_DRIVE_CORE_MACROS_SVH
`define LINE_FOLLOWER_PD_DRIVE_CORE_MACROS_SVH
// Checks that the consequent holds in the same cycle as the antecedent.
`define LFPD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent.
`define LFPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: rtl/lfpd_pkg.sv
// Types, register indexes and constants of the line follower PD drive.
// No dependencies.
package lfpd_pkg;

	typedef enum logic [2:0] {
		CFG_KP        = 3'd0,
		CFG_KD        = 3'd1,
		CFG_BASE      = 3'd2,
		CFG_CURVE     = 3'd3,
		CFG_THRESHOLD = 3'd4,
		CFG_LOST      = 3'd5,
		CFG_HOLD      = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_FOLLOW  = 2'd0,
		MODE_LOST    = 2'd1,
		MODE_PIVOT_R = 2'd2,
		MODE_PIVOT_L = 2'd3
	} drive_mode_t;

	typedef struct packed {
		logic [15:0] kp_q10;
		logic [15:0] kd_q10;
		logic [6:0]  base_speed;
		logic [6:0]  curve_speed;
		logic [10:0] curve_threshold;
		logic [7:0]  lost_line_limit;
		logic [9:0]  corner_hold_ms;
	} cfg_t;

	typedef struct packed {
		drive_mode_t mode;
		logic        left_forward;
		logic [9:0]  left_duty;
		logic        right_forward;
		logic [9:0]  right_duty;
		logic [11:0] line_position;
		logic [2:0]  active_sensors;
	} drive_res_t;

	localparam logic [11:0] POS_CENTRE = 12'd2000;
	localparam logic [9:0]  PIVOT_DUTY = 10'd500;
	localparam logic [7:0]  EMPTY_MAX  = 8'hFF;

	// Weighted mean position for every sensor pattern; the empty pattern is unused.
	localparam logic [11:0] POS_TABLE [32] = '{
		12'd0,    12'd3000, 12'd2500, 12'd2750, 12'd2000, 12'd2500, 12'd2250, 12'd2500,
		12'd1500, 12'd2250, 12'd2000, 12'd2333, 12'd1750, 12'd2166, 12'd2000, 12'd2250,
		12'd1000, 12'd2000, 12'd1750, 12'd2166, 12'd1500, 12'd2000, 12'd1833, 12'd2125,
		12'd1250, 12'd1833, 12'd1666, 12'd2000, 12'd1500, 12'd1875, 12'd1750, 12'd2000
	};

endpackage

// File: rtl/line_follower_pd_drive_core.sv
// Line follower PD drive: a sample is accepted only in the idle state; a tick is handled in idle.
// A following sample goes from eval through P multiply, D multiply, scale and drive to done,
// with two passes through the one shared multiply-accumulate unit; done waits for the output.
// Lost-line and pivot results go from eval straight to done; held or tick items give none.
// Reset is asynchronous: gains and speeds take their defaults, position 2000, counters zero.
`include "line_follower_pd_drive_core_macros.svh"
module line_follower_pd_drive_core
	import lfpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [4:0]  sensors,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  drive_mode,
	output logic        left_forward,
	output logic [9:0]  left_duty,
	output logic        right_forward,
	output logic [9:0]  right_duty,
	output logic [11:0] line_position,
	output logic [2:0]  active_sensors,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_EVAL  = 7'b0000010,
		ST_MUL_P = 7'b0000100,
		ST_MUL_D = 7'b0001000,
		ST_SCALE = 7'b0010000,
		ST_DRIVE = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t state_q;
	cfg_t   cfg;

	logic [11:0] pos_q;
	logic [11:0] prev_q;
	logic [7:0]  cnt_q;
	logic [9:0]  hold_q;
	logic        out_valid_q;

	logic [4:0]         sens_q;
	logic signed [20:0] ms_q;
	logic [6:0]         base_q;
	drive_res_t         res_q;
	drive_res_t         out_q;

	logic               in_acc;
	logic               load;
	logic [2:0]         act;
	logic [11:0]        tab_pos;
	logic [7:0]         cnt_n;
	logic signed [11:0] err;
	logic signed [12:0] diff;
	logic [11:0]        mag;
	logic               mac_en;
	logic               mac_clr;
	logic signed [12:0] mac_a;
	logic [15:0]        mac_b;
	logic signed [30:0] acc;
	logic signed [30:0] acc_adj;
	logic signed [21:0] lsum;
	logic signed [21:0] rsum;
	logic signed [7:0]  lspd;
	logic signed [7:0]  rspd;

	function automatic logic signed [7:0] clamp_speed(input logic signed [21:0] v);
		if (v > 22'sd100) begin
			return 8'sd100;
		end else if (v < -22'sd100) begin
			return -8'sd100;
		end
		return 8'(v);
	endfunction

	function automatic logic [9:0] duty_of(input logic signed [7:0] s);
		logic [9:0] m;
		m = (s < 0) ? 10'(-s) : 10'(s);
		return (m << 3) + (m << 1);
	endfunction

	lfpd_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	lfpd_mac u_mac (
		.clk (clk),
		.en  (mac_en),
		.clr (mac_clr),
		.a   (mac_a),
		.b   (mac_b),
		.acc (acc)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign load      = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign act = 3'(sens_q[0]) + 3'(sens_q[1]) + 3'(sens_q[2]) + 3'(sens_q[3])
		+ 3'(sens_q[4]);
	assign tab_pos = POS_TABLE[sens_q];
	assign cnt_n   = (cnt_q == EMPTY_MAX) ? cnt_q : cnt_q + 8'd1;

	assign err  = 12'($signed({1'b0, pos_q}) - $signed({1'b0, POS_CENTRE}));
	assign diff = {err[11], err} - {prev_q[11], prev_q};
	assign mag  = err[11] ? 12'(-err) : 12'(err);

	assign mac_en  = (state_q == ST_MUL_P) || (state_q == ST_MUL_D);
	assign mac_clr = (state_q == ST_MUL_P);
	assign mac_a   = (state_q == ST_MUL_P) ? {err[11], err} : diff;
	assign mac_b   = (state_q == ST_MUL_P) ? cfg.kp_q10 : cfg.kd_q10;

	assign acc_adj = acc + (acc[30] ? 31'sd1023 : 31'sd0);

	assign lsum = $signed({15'd0, base_q}) - {ms_q[20], ms_q};
	assign rsum = $signed({15'd0, base_q}) + {ms_q[20], ms_q};
	assign lspd = clamp_speed(lsum);
	assign rspd = clamp_speed(rsum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= POS_CENTRE;
			prev_q      <= '0;
			cnt_q       <= '0;
			hold_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (!kind) begin
							if (hold_q != '0) begin
								hold_q <= hold_q - 10'd1;
							end
						end else if (hold_q == '0) begin
							state_q <= ST_EVAL;
						end
					end
				end
				ST_EVAL: begin
					if (act == '0) begin
						cnt_q   <= cnt_n;
						state_q <= (cnt_n > cfg.lost_line_limit) ? ST_DONE : ST_MUL_P;
					end else begin
						cnt_q <= '0;
						pos_q <= tab_pos;
						if (sens_q[4] != sens_q[0]) begin
							hold_q  <= cfg.corner_hold_ms;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_MUL_P;
						end
					end
				end
				ST_MUL_P: state_q <= ST_MUL_D;
				ST_MUL_D: begin
					prev_q  <= err;
					state_q <= ST_SCALE;
				end
				ST_SCALE: state_q <= ST_DRIVE;
				ST_DRIVE: state_q <= ST_DONE;
				ST_DONE: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sens_q <= sensors;
		end
		if (state_q == ST_SCALE) begin
			ms_q   <= acc_adj[30:10];
			base_q <= ({1'b0, mag} >= {2'b0, cfg.curve_threshold}) ? cfg.curve_speed
				: cfg.base_speed;
		end
		if (state_q == ST_EVAL) begin
			res_q.active_sensors <= act;
			res_q.line_position  <= (act == '0) ? pos_q : tab_pos;
			if (act == '0) begin
				res_q.mode          <= MODE_LOST;
				res_q.left_forward  <= 1'b1;
				res_q.left_duty     <= '0;
				res_q.right_forward <= 1'b1;
				res_q.right_duty    <= '0;
			end else if (sens_q[4]) begin
				res_q.mode          <= MODE_PIVOT_R;
				res_q.left_forward  <= 1'b1;
				res_q.left_duty     <= PIVOT_DUTY;
				res_q.right_forward <= 1'b0;
				res_q.right_duty    <= PIVOT_DUTY;
			end else begin
				res_q.mode          <= MODE_PIVOT_L;
				res_q.left_forward  <= 1'b0;
				res_q.left_duty     <= PIVOT_DUTY;
				res_q.right_forward <= 1'b1;
				res_q.right_duty    <= PIVOT_DUTY;
			end
		end
		if (state_q == ST_DRIVE) begin
			res_q.mode          <= MODE_FOLLOW;
			res_q.left_forward  <= (lspd >= 0);
			res_q.left_duty     <= duty_of(lspd);
			res_q.right_forward <= (rspd >= 0);
			res_q.right_duty    <= duty_of(rspd);
			res_q.line_position <= pos_q;
		end
		if (load) begin
			out_q <= res_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign drive_mode     = out_q.mode;
	assign left_forward   = out_q.left_forward;
	assign left_duty      = out_q.left_duty;
	assign right_forward  = out_q.right_forward;
	assign right_duty     = out_q.right_duty;
	assign line_position  = out_q.line_position;
	assign active_sensors = out_q.active_sensors;

	`LFPD_ASSERT_NEXT(a_tick_counts_down, in_acc && !kind && hold_q != '0,
		hold_q == $past(hold_q) - 10'd1, "Tick did not decrement the hold counter.")
	`LFPD_ASSERT_NEXT(a_held_sample_dropped, in_acc && kind && hold_q != '0,
		state_q == ST_IDLE, "Sample during hold was processed.")
	`LFPD_ASSERT_NOW(a_lost_is_stopped, out_valid_q && drive_mode == MODE_LOST,
		left_duty == '0 && right_duty == '0 && active_sensors == '0,
		"Lost-line item drives the motors.")
	`LFPD_ASSERT_NEXT(a_done_delivers, state_q == ST_DONE && !out_valid_q,
		out_valid_q && state_q == ST_IDLE, "Finished item was not presented.")

endmodule

// File: rtl/lfpd_regs.sv
// Configuration register file of the line follower PD drive.
// Depends on lfpd_pkg.
module lfpd_regs
	import lfpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [15:0] wr_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_q10          <= 16'd31;
			cfg_q.kd_q10          <= 16'd1536;
			cfg_q.base_speed      <= 7'd40;
			cfg_q.curve_speed     <= 7'd40;
			cfg_q.curve_threshold <= 11'd500;
			cfg_q.lost_line_limit <= 8'd40;
			cfg_q.corner_hold_ms  <= 10'd100;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_KP:        cfg_q.kp_q10          <= wr_data;
				CFG_KD:        cfg_q.kd_q10          <= wr_data;
				CFG_BASE:      cfg_q.base_speed      <= wr_data[6:0];
				CFG_CURVE:     cfg_q.curve_speed     <= wr_data[6:0];
				CFG_THRESHOLD: cfg_q.curve_threshold <= wr_data[10:0];
				CFG_LOST:      cfg_q.lost_line_limit <= wr_data[7:0];
				CFG_HOLD:      cfg_q.corner_hold_ms  <= wr_data[9:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/lfpd_mac.sv
// Shared multiply-accumulate unit: signed operand times unsigned gain.
// Depends on lfpd_pkg only by convention; no submodules.
module lfpd_mac
	import lfpd_pkg::*;
(
	input  logic               clk,
	input  logic               en,
	input  logic               clr,
	input  logic signed [12:0] a,
	input  logic        [15:0] b,
	output logic signed [30:0] acc
);

	logic signed [29:0] prod;
	logic signed [30:0] acc_q;

	assign prod = a * $signed({1'b0, b});

	always_ff @(posedge clk) begin
		if (en) begin
			acc_q <= (clr ? 31'sd0 : acc_q) + 31'(prod);
		end
	end

	assign acc = acc_q;

endmodule

// File: bench/tb_line_follower_pd_drive_core.sv
// Self-checking bench for line_follower_pd_drive_core: sensor samples and ticks go in,
// and every drive result is compared with a PD drive predictor kept inside this bench.
// Depends on lfpd_pkg and the core RTL only.
module tb_line_follower_pd_drive_core
	import lfpd_pkg::*;
();

	localparam int RESET_CYCLES = 7;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_CYCLES = 20;
	localparam int RUN_LIMIT = 5_000_000;
	localparam int PIVOT_SPEED = 50;
	localparam int SPEED_LIMIT = 100;
	localparam int DUTY_SCALE = 10;
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        kind = 1'b0;
	logic [4:0]  sensors = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  drive_mode;
	logic        left_forward;
	logic [9:0]  left_duty;
	logic        right_forward;
	logic [9:0]  right_duty;
	logic [11:0] line_position;
	logic [2:0]  active_sensors;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	line_follower_pd_drive_core dut (.*);

	// Predictor state and register copy.
	cfg_t regs = '{16'd31, 16'd1536, 7'd40, 7'd40, 11'd500, 8'd40, 10'd100};
	logic [11:0] line_pos = POS_CENTRE;
	int last_error = 0;
	int empty_run = 0;
	int hold_ticks = 0;

	logic [5:0]  outgoing_items[$];
	drive_res_t  expected_drive[$];
	int items_sent = 0;
	int items_taken = 0;
	int results_due = 0;
	int mismatches = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int ready_hold_cycles = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int clamp_speed(input int v);
		if (v > SPEED_LIMIT) return SPEED_LIMIT;
		if (v < -SPEED_LIMIT) return -SPEED_LIMIT;
		return v;
	endfunction

	function automatic drive_res_t make_drive(input drive_mode_t m, input int l, input int r,
			input int act);
		drive_res_t d;
		d.mode = m;
		d.left_forward = (l >= 0);
		d.left_duty = 10'((l < 0 ? -l : l) * DUTY_SCALE);
		d.right_forward = (r >= 0);
		d.right_duty = 10'((r < 0 ? -r : r) * DUTY_SCALE);
		d.line_position = line_pos;
		d.active_sensors = 3'(act);
		return d;
	endfunction

	function automatic bit predict_drive(input logic k, input logic [4:0] s,
			output drive_res_t r);
		int act, sum, err, diff, mag, base, motor;
		longint acc;
		act = 0;
		sum = 0;
		if (k == KIND_TICK) begin
			if (hold_ticks > 0) hold_ticks--;
			return 0;
		end
		if (hold_ticks > 0) return 0;
		for (int i = 0; i < 5; i++) begin
			if (s[i]) begin
				sum += 3000 - 500 * i;
				act++;
			end
		end
		if (act == 0) begin
			if (empty_run < 255) empty_run++;
			if (empty_run > int'(regs.lost_line_limit)) begin
				r = make_drive(MODE_LOST, 0, 0, 0);
				return 1;
			end
		end else begin
			empty_run = 0;
			line_pos = 12'(sum / act);
		end
		if (s[4] && !s[0]) begin
			r = make_drive(MODE_PIVOT_R, PIVOT_SPEED, -PIVOT_SPEED, act);
			hold_ticks = regs.corner_hold_ms;
			return 1;
		end
		if (s[0] && !s[4]) begin
			r = make_drive(MODE_PIVOT_L, -PIVOT_SPEED, PIVOT_SPEED, act);
			hold_ticks = regs.corner_hold_ms;
			return 1;
		end
		err = int'(line_pos) - int'(POS_CENTRE);
		diff = err - last_error;
		acc = longint'(err) * longint'(regs.kp_q10) + longint'(diff) * longint'(regs.kd_q10);
		motor = int'(acc / 1024);
		mag = (err < 0) ? -err : err;
		base = (mag >= int'(regs.curve_threshold)) ? int'(regs.curve_speed)
			: int'(regs.base_speed);
		last_error = err;
		r = make_drive(MODE_FOLLOW, clamp_speed(base - motor), clamp_speed(base + motor), act);
		return 1;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t  %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Observes all three channels at each edge, before any update of this edge lands.
	always @(posedge clk) begin : observe
		drive_res_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_drive.size() == 0) begin
					$display("%0t  drive result with no expectation waiting: mode %0d",
						$time, drive_mode);
					mismatches++;
				end else begin
					want = expected_drive.pop_front();
					check_field("drive_mode", want.mode, drive_mode);
					check_field("left_forward", want.left_forward, left_forward);
					check_field("left_duty", want.left_duty, left_duty);
					check_field("right_forward", want.right_forward, right_forward);
					check_field("right_duty", want.right_duty, right_duty);
					check_field("line_position", want.line_position, line_position);
					check_field("active_sensors", want.active_sensors, active_sensors);
				end
			end
			if (in_valid && in_ready) begin
				items_taken++;
				if (predict_drive(kind, sensors, want)) begin
					expected_drive.push_back(want);
					results_due++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_KP: regs.kp_q10 = cfg_data;
					CFG_KD: regs.kd_q10 = cfg_data;
					CFG_BASE: regs.base_speed = cfg_data[6:0];
					CFG_CURVE: regs.curve_speed = cfg_data[6:0];
					CFG_THRESHOLD: regs.curve_threshold = cfg_data[10:0];
					CFG_LOST: regs.lost_line_limit = cfg_data[7:0];
					CFG_HOLD: regs.corner_hold_ms = cfg_data[9:0];
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (!in_valid || in_ready) begin
			if (outgoing_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				{kind, sensors} <= outgoing_items.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (ready_hold_cycles > 0) begin
			out_ready <= 1'b0;
			ready_hold_cycles--;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_item(input logic k, input logic [4:0] s);
		outgoing_items.push_back({k, s});
		items_sent++;
		while (outgoing_items.size() > 1) @(posedge clk);
	endtask

	task automatic wait_results();
		while (outgoing_items.size() > 0 || items_taken != items_sent
				|| expected_drive.size() > 0)
			@(posedge clk);
	endtask

	task automatic load_settings(input cfg_t c);
		cfg_idx_t idx;
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		idx = idx.first();
		do begin
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			case (idx)
				CFG_KP: cfg_data <= c.kp_q10;
				CFG_KD: cfg_data <= c.kd_q10;
				CFG_BASE: cfg_data <= 16'(c.base_speed);
				CFG_CURVE: cfg_data <= 16'(c.curve_speed);
				CFG_THRESHOLD: cfg_data <= 16'(c.curve_threshold);
				CFG_LOST: cfg_data <= 16'(c.lost_line_limit);
				CFG_HOLD: cfg_data <= 16'(c.corner_hold_ms);
				default: cfg_data <= '0;
			endcase
			do @(posedge clk); while (!cfg_ready);
			idx = idx.next();
		end while (idx != idx.first());
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [4:0] track_pattern();
		int w, lo;
		w = $urandom_range(1, 3);
		lo = $urandom_range(0, 5 - w);
		return 5'(((1 << w) - 1) << lo);
	endfunction

	function automatic cfg_t random_settings();
		cfg_t c;
		c.kp_q10 = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
		c.kd_q10 = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
		c.base_speed = ($urandom_range(4) == 0) ? 7'($urandom_range(101, 127))
			: 7'($urandom_range(0, 100));
		c.curve_speed = ($urandom_range(4) == 0) ? 7'($urandom_range(101, 127))
			: 7'($urandom_range(0, 100));
		c.curve_threshold = 11'($urandom_range(0, 2047));
		c.lost_line_limit = ($urandom_range(7) == 0) ? 8'd255 : 8'($urandom_range(0, 6));
		c.corner_hold_ms = 10'($urandom_range(0, 6));
		return c;
	endfunction

	// Mostly track-like samples; a pivot is followed by enough ticks to release its hold.
	task automatic random_step();
		logic [4:0] s;
		logic [2:0] mid;
		int pick;
		pick = $urandom_range(99);
		mid = 3'($urandom);
		if (pick < 50) begin
			s = track_pattern();
		end else if (pick < 62) begin
			repeat ($urandom_range(1, 8)) send_item(KIND_SAMPLE, 5'd0);
			return;
		end else if (pick < 74) begin
			s = $urandom_range(1) ? {1'b1, mid, 1'b0} : {1'b0, mid, 1'b1};
		end else if (pick < 86) begin
			send_item(KIND_TICK, 5'($urandom_range(31)));
			return;
		end else begin
			s = 5'($urandom_range(31));
		end
		send_item(KIND_SAMPLE, s);
		if (s[4] != s[0]) begin
			if ($urandom_range(3) == 0) send_item(KIND_SAMPLE, track_pattern());
			repeat (regs.corner_hold_ms) send_item(KIND_TICK, 5'($urandom_range(31)));
		end
	endtask

	task automatic test_reset_defaults();
		send_item(KIND_SAMPLE, 5'b00100);
		send_item(KIND_SAMPLE, 5'b01110);
		send_item(KIND_SAMPLE, 5'b11111);
		send_item(KIND_SAMPLE, 5'b10001);
		send_item(KIND_SAMPLE, 5'b11001);
		send_item(KIND_SAMPLE, 5'b00110);
		send_item(KIND_SAMPLE, 5'b01100);
		send_item(KIND_SAMPLE, 5'b00010);
		send_item(KIND_TICK, 5'b11111);
		send_item(KIND_SAMPLE, 5'b00000);
	endtask

	task automatic test_directed();
		load_settings('{16'd2048, 16'd1536, 7'd60, 7'd20, 11'd400, 8'd2, 10'd2});
		send_item(KIND_SAMPLE, 5'b00100);
		// A pivot, a sample ignored under the hold, then the ticks that end it.
		send_item(KIND_SAMPLE, 5'b10000);
		send_item(KIND_SAMPLE, 5'b00100);
		send_item(KIND_TICK, 5'b00000);
		send_item(KIND_TICK, 5'b11111);
		send_item(KIND_TICK, 5'b00000);
		send_item(KIND_SAMPLE, 5'b00001);
		send_item(KIND_TICK, 5'b00000);
		send_item(KIND_TICK, 5'b00000);
		// Empty samples run on the kept outer position until the line counts as lost.
		repeat (4) send_item(KIND_SAMPLE, 5'b00000);
		send_item(KIND_SAMPLE, 5'b11111);
		send_item(KIND_SAMPLE, 5'b00011);
		send_item(KIND_TICK, 5'b00000);
		send_item(KIND_TICK, 5'b00000);
		send_item(KIND_SAMPLE, 5'b11000);
		send_item(KIND_TICK, 5'b00000);
		send_item(KIND_TICK, 5'b00000);
		send_item(KIND_SAMPLE, 5'b10001);
		send_item(KIND_SAMPLE, 5'b01010);
		send_item(KIND_SAMPLE, 5'b11011);
		send_item(KIND_SAMPLE, 5'b01100);
	endtask

	task automatic test_config_extremes();
		send_idle_pct = 13;
		stall_pct = 13;
		load_settings('{16'd0, 16'd0, 7'd0, 7'd0, 11'd0, 8'd0, 10'd0});
		repeat (5) random_step();
		load_settings('{16'hFFFF, 16'hFFFF, 7'd127, 7'd127, 11'd2047, 8'd255, 10'd8});
		repeat (16) send_item(KIND_SAMPLE, 5'b00000);
		repeat (5) random_step();
		// The empty count saturates at its top value instead of wrapping.
		load_settings('{16'd1024, 16'd0, 7'd100, 7'd100, 11'd2000, 8'd254, 10'd1});
		repeat (256) send_item(KIND_SAMPLE, 5'b00000);
		repeat (5) random_step();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		load_settings('{16'd400, 16'd800, 7'd50, 7'd30, 11'd300, 8'd3, 10'd0});
		ready_hold_cycles = 300;
		repeat (15) random_step();
		while (ready_hold_cycles > 0) @(posedge clk);
		wait_results();
		repeat (6) random_step();
	endtask

	task automatic test_random();
		int start;
		for (int seg = 0; seg < 8; seg++) begin
			load_settings(random_settings());
			case (seg / 2)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 51; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 51; end
				default: begin send_idle_pct = 13; stall_pct = 13; end
			endcase
			start = results_due;
			while (results_due - start < 5) random_step();
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_directed();
		test_config_extremes();
		test_backpressure();
		test_random();
		wait_results();
		repeat (END_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#(RUN_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/lfpd_pkg.sv
rtl/lfpd_regs.sv
rtl/lfpd_mac.sv
rtl/line_follower_pd_drive_core.sv
bench/tb_line_follower_pd_drive_core.sv
